// ===== rtl/bcts_pkg.sv =====
// ============================================================================
// bcts_pkg: shared types and constants for the coin-cell test sequencer
// Holds the phase encoding, the register layout, the request codes and the
// small helper functions used by both the top level and the step logic.
// ============================================================================
`default_nettype none

package bcts_pkg;

    // Timer width default; the phase time limits below must fit in it.
    localparam int TIMER_BITS_DEFAULT = 20;

    // Field widths fixed by the interface.
    localparam int MV_BITS     = 13;
    localparam int COUNT_BITS  = 8;
    localparam int MODE_BITS   = 2;
    localparam int COLOUR_BITS = 2;
    localparam int LEVEL_BITS  = 8;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 13;

    // Packed stream widths (data widths padded to whole bytes).
    localparam int S_TDATA_BITS = 16;
    localparam int S_TUSER_BITS = 1;
    localparam int M_TDATA_BITS = 16;

    // Request operation codes carried on s_tuser.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_SEQUENCE_SELECT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OVERVOLT_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNDERVOLT_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RECH_STOP         = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PRIM_STOP         = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_ERROR_CONFIRM     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_DONE_CONFIRM      = 3'd6;

    // Sequence selection codes.
    localparam logic SEQ_RECHARGEABLE = 1'b0;
    localparam logic SEQ_PRIMARY      = 1'b1;

    // Register reset values.
    localparam logic                  RST_SEQUENCE_SELECT = SEQ_PRIMARY;
    localparam logic [MV_BITS-1:0]    RST_OVERVOLT_MV     = 13'd4300;
    localparam logic [MV_BITS-1:0]    RST_UNDERVOLT_MV    = 13'd3000;
    localparam logic [MV_BITS-1:0]    RST_RECH_STOP_MV    = 13'd3300;
    localparam logic [MV_BITS-1:0]    RST_PRIM_STOP_MV    = 13'd1500;
    localparam logic [COUNT_BITS-1:0] RST_ERROR_CONFIRM   = 8'd5;
    localparam logic [COUNT_BITS-1:0] RST_DONE_CONFIRM    = 8'd3;

    // Phase time limits in ticks (one tick per second).
    localparam int CHG_MAX_TICKS  = 2 * 60 * 60;
    localparam int DIS_MAX_TICKS  = 4 * 60 * 60;
    localparam int CHG1_MIN_TICKS = 0;
    localparam int DIS_MIN_TICKS  = 1 * 60 * 60;
    localparam int CHG2_MIN_TICKS = 20 * 60;
    localparam int PRIM_MIN_TICKS = 1 * 60 * 60;

    // Bar level: 1 + floor((mV - 3300) * 6 / 900) = 1 + floor(lvl / 150).
    // lvl / 150 is taken as (lvl * 6991) >> 20, exact for every 13-bit lvl.
    localparam int BAR_BASE_MV  = 3300;
    localparam int BAR_RECIP    = 6991;
    localparam int BAR_SHIFT    = 20;
    localparam int BAR_PROD_BITS = MV_BITS + 13;
    localparam logic [LEVEL_BITS-1:0] BAR_FULL = 8'd255;
    localparam logic [LEVEL_BITS-1:0] BAR_ONE  = 8'd1;

    // Drive modes.
    localparam logic [MODE_BITS-1:0] MODE_FREE   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_CHARGE = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_LOAD   = 2'd2;

    // LED colours.
    localparam logic [COLOUR_BITS-1:0] COLOUR_GREEN  = 2'd0;
    localparam logic [COLOUR_BITS-1:0] COLOUR_YELLOW = 2'd1;
    localparam logic [COLOUR_BITS-1:0] COLOUR_RED    = 2'd2;

    // Test phase, one-hot.
    typedef enum logic [5:0] {
        PH_CHG1 = 6'b000001,
        PH_DIS1 = 6'b000010,
        PH_CHG2 = 6'b000100,
        PH_PRIM = 6'b001000,
        PH_DONE = 6'b010000,
        PH_ERR  = 6'b100000
    } phase_t;

    // Configuration register file.
    typedef struct packed {
        logic                  sequence_select;
        logic [MV_BITS-1:0]    overvolt_limit_mv;
        logic [MV_BITS-1:0]    undervolt_limit_mv;
        logic [MV_BITS-1:0]    rech_discharge_stop_mv;
        logic [MV_BITS-1:0]    prim_discharge_stop_mv;
        logic [COUNT_BITS-1:0] error_confirm_count;
        logic [COUNT_BITS-1:0] done_confirm_count;
    } cfg_t;

    // Sequencer state apart from the phase timer.
    typedef struct packed {
        phase_t                phase;
        logic [COUNT_BITS-1:0] error_streak;
        logic [COUNT_BITS-1:0] done_streak;
        logic [LEVEL_BITS-1:0] bar_level;
    } seq_state_t;

    // One result item.
    typedef struct packed {
        logic                   failed;
        logic                   finished;
        logic [LEVEL_BITS-1:0]  led_bar;
        logic [COLOUR_BITS-1:0] led_colour;
        logic [MODE_BITS-1:0]   drive_mode;
    } result_t;

    // First phase of a sequence.
    function automatic phase_t first_phase(input logic seq_sel);
        return (seq_sel == SEQ_PRIMARY) ? PH_PRIM : PH_CHG1;
    endfunction

    // Saturating streak increment.
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Bar level from a voltage sample.
    function automatic logic [LEVEL_BITS-1:0] bar_from_mv(input logic [MV_BITS-1:0] mv);
        logic [MV_BITS-1:0]       lvl;
        logic [BAR_PROD_BITS-1:0] prod;
        lvl  = (mv > MV_BITS'(BAR_BASE_MV)) ? mv - MV_BITS'(BAR_BASE_MV) : '0;
        prod = BAR_PROD_BITS'(lvl) * BAR_PROD_BITS'(BAR_RECIP);
        return LEVEL_BITS'(prod[BAR_PROD_BITS-1:BAR_SHIFT]) + BAR_ONE;
    endfunction

    // Drive mode of a phase.
    function automatic logic [MODE_BITS-1:0] mode_of(input phase_t ph);
        logic [MODE_BITS-1:0] m;
        case (ph)
            PH_CHG1, PH_CHG2: m = MODE_CHARGE;
            PH_DIS1, PH_PRIM: m = MODE_LOAD;
            default:          m = MODE_FREE;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bcts_step.sv =====
// ============================================================================
// bcts_step: next-state and result logic for one request
// Classifies the sample for the current phase, updates the streaks, the
// phase timer and the bar level, and forms the result item.
// ============================================================================
`default_nettype none

module bcts_step
    import bcts_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
    input  wire cfg_t                    cfg,
    input  wire seq_state_t              state,
    input  wire logic [TIMER_BITS-1:0]   ticks,
    input  wire logic                    operation,
    input  wire logic [MV_BITS-1:0]      battery_mv,
    input  wire logic                    charger_done,
    output seq_state_t                   state_next,
    output logic [TIMER_BITS-1:0]        ticks_next,
    output result_t                      result
);

    localparam logic [TIMER_BITS-1:0] CHG_MAX  = TIMER_BITS'(CHG_MAX_TICKS);
    localparam logic [TIMER_BITS-1:0] DIS_MAX  = TIMER_BITS'(DIS_MAX_TICKS);
    localparam logic [TIMER_BITS-1:0] CHG1_MIN = TIMER_BITS'(CHG1_MIN_TICKS);
    localparam logic [TIMER_BITS-1:0] DIS_MIN  = TIMER_BITS'(DIS_MIN_TICKS);
    localparam logic [TIMER_BITS-1:0] CHG2_MIN = TIMER_BITS'(CHG2_MIN_TICKS);
    localparam logic [TIMER_BITS-1:0] PRIM_MIN = TIMER_BITS'(PRIM_MIN_TICKS);

    // Per-phase attributes.
    logic                    active;
    logic                    charging;
    logic                    has_max;
    logic [TIMER_BITS-1:0]   max_ticks;
    logic [TIMER_BITS-1:0]   min_ticks;
    phase_t                  next_phase;
    logic [MV_BITS-1:0]      stop_mv;
    logic [COLOUR_BITS-1:0]  colour;
    logic                    terminal;
    logic                    in_error;

    always_comb begin
        active     = 1'b1;
        charging   = 1'b0;
        has_max    = 1'b1;
        max_ticks  = CHG_MAX;
        min_ticks  = CHG1_MIN;
        next_phase = PH_DONE;
        stop_mv    = cfg.prim_discharge_stop_mv;
        colour     = COLOUR_GREEN;
        terminal   = 1'b0;
        in_error   = 1'b0;
        case (state.phase)
            PH_CHG1: begin
                charging   = 1'b1;
                next_phase = PH_DIS1;
            end
            PH_DIS1: begin
                max_ticks  = DIS_MAX;
                min_ticks  = DIS_MIN;
                next_phase = PH_CHG2;
                stop_mv    = cfg.rech_discharge_stop_mv;
                colour     = COLOUR_YELLOW;
            end
            PH_CHG2: begin
                charging   = 1'b1;
                min_ticks  = CHG2_MIN;
            end
            PH_PRIM: begin
                has_max    = 1'b0;
                min_ticks  = PRIM_MIN;
                colour     = COLOUR_YELLOW;
            end
            PH_DONE: begin
                active     = 1'b0;
                terminal   = 1'b1;
            end
            default: begin
                // Error phase, and any code that should never appear.
                active     = 1'b0;
                terminal   = 1'b1;
                in_error   = 1'b1;
                colour     = COLOUR_RED;
            end
        endcase
    end

    // Sample classification and the phase decision.
    logic                  smp_err;
    logic                  smp_done;
    logic [COUNT_BITS-1:0] err_inc;
    logic [COUNT_BITS-1:0] done_inc;
    logic                  go_err;
    logic                  go_adv;

    always_comb begin
        err_inc  = sat_inc(state.error_streak);
        done_inc = sat_inc(state.done_streak);
        if (charging) begin
            smp_done = charger_done;
            smp_err  = !charger_done && ((battery_mv > cfg.overvolt_limit_mv) ||
                                         (battery_mv < cfg.undervolt_limit_mv));
        end else begin
            smp_err  = charger_done || (battery_mv > cfg.overvolt_limit_mv);
            smp_done = !smp_err && (battery_mv < stop_mv);
        end

        go_err = has_max && (ticks > max_ticks);
        go_adv = 1'b0;
        if (smp_err) begin
            if (err_inc >= cfg.error_confirm_count) begin
                go_err = 1'b1;
            end
        end else if (smp_done) begin
            if (done_inc >= cfg.done_confirm_count) begin
                if (ticks < min_ticks) begin
                    go_err = 1'b1;
                end else begin
                    go_adv = 1'b1;
                end
            end
        end
    end

    // State update.
    always_comb begin
        state_next = state;
        ticks_next = ticks;
        if (operation == OP_RESTART) begin
            state_next.phase        = first_phase(cfg.sequence_select);
            state_next.error_streak = '0;
            state_next.done_streak  = '0;
            ticks_next              = '0;
        end else if (!active) begin
            state_next.bar_level = BAR_FULL;
        end else begin
            state_next.bar_level = (state.phase == PH_CHG1) ? BAR_ONE
                                                            : bar_from_mv(battery_mv);
            if (smp_err) begin
                state_next.error_streak = err_inc;
            end else if (smp_done) begin
                state_next.done_streak = done_inc;
            end else begin
                state_next.error_streak = '0;
                state_next.done_streak  = '0;
            end
            if (go_err || go_adv) begin
                ticks_next       = '0;
                state_next.phase = go_err ? PH_ERR : next_phase;
            end else if (ticks != '1) begin
                ticks_next = ticks + 1'b1;
            end
        end
    end

    // Result item.
    always_comb begin
        result.drive_mode = mode_of(state_next.phase);
        result.led_colour = colour;
        result.led_bar    = state_next.bar_level;
        result.finished   = terminal;
        result.failed     = in_error;
    end

endmodule

`default_nettype wire

// ===== rtl/battery_cycle_test_sequencer.sv =====
// ============================================================================
// battery_cycle_test_sequencer: coin-cell charge/discharge test sequencer
// Steps a cell through the rechargeable or primary test sequence, one sample
// request per tick, and reports drive mode, LED state and done/error flags.
// ============================================================================
// Pipeline: a request accepted on the slave port is loaded into the input
// register; the result register takes its result when the input stage
// moves on, which a result held by m_tready low can delay.
// Throughput: one request per cycle while results are taken (m_tready high); the
// state update is a single pass of logic between the input and result registers.
// Reset: synchronous, active low; the control, configuration and state registers take
// their reset values and the phase starts at the first phase of the primary sequence.
`default_nettype none

module battery_cycle_test_sequencer
    import bcts_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Configuration write port.
    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    // Sample requests.
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [S_TDATA_BITS-1:0]   s_tdata,  // battery_mv[12:0], charger_done[13]
    input  wire logic [S_TUSER_BITS-1:0]   s_tuser,  // operation[0]
    // Results.
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [M_TDATA_BITS-1:0]        m_tdata   // drive_mode[1:0], led_colour[3:2],
                                                     // led_bar[11:4], finished[12],
                                                     // failed[13]
);

    // Configuration registers.
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sequence_select        <= RST_SEQUENCE_SELECT;
            cfg_reg.overvolt_limit_mv      <= RST_OVERVOLT_MV;
            cfg_reg.undervolt_limit_mv     <= RST_UNDERVOLT_MV;
            cfg_reg.rech_discharge_stop_mv <= RST_RECH_STOP_MV;
            cfg_reg.prim_discharge_stop_mv <= RST_PRIM_STOP_MV;
            cfg_reg.error_confirm_count    <= RST_ERROR_CONFIRM;
            cfg_reg.done_confirm_count     <= RST_DONE_CONFIRM;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SEQUENCE_SELECT: cfg_reg.sequence_select        <= cfg_wdata[0];
                REG_OVERVOLT_LIMIT:  cfg_reg.overvolt_limit_mv      <= cfg_wdata;
                REG_UNDERVOLT_LIMIT: cfg_reg.undervolt_limit_mv     <= cfg_wdata;
                REG_RECH_STOP:       cfg_reg.rech_discharge_stop_mv <= cfg_wdata;
                REG_PRIM_STOP:       cfg_reg.prim_discharge_stop_mv <= cfg_wdata;
                REG_ERROR_CONFIRM:   cfg_reg.error_confirm_count    <= cfg_wdata[COUNT_BITS-1:0];
                REG_DONE_CONFIRM:    cfg_reg.done_confirm_count     <= cfg_wdata[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline control: the input stage moves on when the result register
    // is free or is being emptied in the same cycle.
    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    // Input register.
    logic               op_reg;
    logic [MV_BITS-1:0] mv_reg;
    logic               chg_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg       <= s_tuser[0];
            mv_reg       <= s_tdata[MV_BITS-1:0];
            chg_done_reg <= s_tdata[MV_BITS];
        end
    end

    // Sequencer state.
    seq_state_t            state_reg;
    seq_state_t            state_next;
    logic [TIMER_BITS-1:0] ticks_reg;
    logic [TIMER_BITS-1:0] ticks_next;
    result_t               result_next;

    bcts_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .cfg          (cfg_reg),
        .state        (state_reg),
        .ticks        (ticks_reg),
        .operation    (op_reg),
        .battery_mv   (mv_reg),
        .charger_done (chg_done_reg),
        .state_next   (state_next),
        .ticks_next   (ticks_next),
        .result       (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase        <= first_phase(RST_SEQUENCE_SELECT);
            state_reg.error_streak <= '0;
            state_reg.done_streak  <= '0;
            state_reg.bar_level    <= '0;
            ticks_reg              <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            ticks_reg <= ticks_next;
        end
    end

    // Result register.
    result_t result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tdata = {2'b00, result_reg};

endmodule

`default_nettype wire
